>>> design/upn_pkg.sv
// Shared types, character constants and character-class functions for the URL normalizer.
package upn_pkg;

	localparam logic [7:0] PCT      = 8'h25; // '%'
	localparam logic [7:0] CHAR_DEL = 8'h7f;
	localparam logic [7:0] HI_MASK  = 8'hf0;
	localparam logic [7:0] LO_MASK  = 8'h0f;

	// Decoded byte handed from the decode front to the escape back end.
	// rsv: run-ending reserved byte, written as is after the escape stage flushes.
	// last: final token of a string; on a data token the escape stage flushes after it.
	typedef struct packed {
		logic [7:0] data;
		logic       rsv;
		logic       last;
	} tok_t;

	// One output unit of the escape stage: a byte, either literal or as %XX.
	typedef struct packed {
		logic [7:0] data;
		logic       esc;
	} unit_t;

	localparam int TOK_W = $bits(tok_t);

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	function automatic logic [3:0] hex_val(input logic [7:0] c);
		logic [7:0] v;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = c - 8'h57;
		end else begin
			v = (c - 8'h37) & LO_MASK;
		end
		return v[3:0];
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
	endfunction

	function automatic logic is_reserved(input logic [7:0] c);
		logic r;
		case (c)
			8'h2d, 8'h5f, 8'h2e, 8'h21, 8'h7e, 8'h2a, 8'h27, 8'h28, 8'h29,
			8'h3b, 8'h2f, 8'h3f, 8'h3a, 8'h40, 8'h26, 8'h3d, 8'h2b, 8'h24,
			8'h2c: r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

	// Letters, digits, DEL (8'h7f) and high bytes pass; everything else becomes %XX.
	function automatic logic needs_esc(input logic [7:0] d);
		logic pass;
		pass = (d >= 8'h41 && d <= 8'h5a) || (d >= 8'h61 && d <= 8'h7a) ||
			(d >= 8'h30 && d <= 8'h39) || (d >= CHAR_DEL);
		return !pass;
	endfunction

endpackage

>>> design/upn_fifo.sv
// Small register queue used between the stages and at the output.
module upn_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] rdata,
	output logic         empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [W-1:0] mem_q [DEPTH];
	logic [AW-1:0] wptr_q, rptr_q;
	logic [AW:0] cnt_q;
	logic do_push, do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

>>> design/upn_front.sv
// Decode front: takes raw bytes, percent-decodes runs, issues decoded tokens one per cycle unless tok_full.
module upn_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	output logic             full,
	output logic             tok_push,
	output upn_pkg::tok_t    tok_data,
	input  logic             tok_full
);

	logic [1:0] dcnt_q;
	logic [7:0] dh0_q, dh1_q;
	upn_pkg::tok_t list_q [3];
	logic [1:0] rem_q, idx_q;

	upn_pkg::tok_t nl [3];
	logic [1:0] nn, ncnt;
	logic [7:0] nh0, nh1;
	logic accept, emit;

	assign emit     = (rem_q != 2'd0) && !tok_full;
	assign full     = (rem_q != 2'd0) && !(emit && rem_q == 2'd1);
	assign accept   = push && !full;
	assign tok_push = emit;
	assign tok_data = list_q[idx_q];

	// Up to three tokens per byte: held bytes that fail, the byte itself, flush at string end.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nl[i] = '0;
		end
		nn   = 2'd0;
		ncnt = dcnt_q;
		nh0  = dh0_q;
		nh1  = dh1_q;
		if (upn_pkg::is_reserved(in_byte)) begin
			if (dcnt_q != 2'd0) begin
				nl[nn] = '{data: dh0_q, rsv: 1'b0, last: 1'b0};
				nn = nn + 2'd1;
			end
			if (dcnt_q == 2'd2) begin
				nl[nn] = '{data: dh1_q, rsv: 1'b0, last: 1'b0};
				nn = nn + 2'd1;
			end
			nl[nn] = '{data: in_byte, rsv: 1'b1, last: in_last};
			nn = nn + 2'd1;
			ncnt = 2'd0;
		end else begin
			if (dcnt_q == 2'd1 && upn_pkg::is_hex(in_byte)) begin
				nh1  = in_byte;
				ncnt = 2'd2;
			end else if (dcnt_q == 2'd2 && upn_pkg::is_hex(in_byte)) begin
				nl[nn] = '{data: {upn_pkg::hex_val(dh1_q), upn_pkg::hex_val(in_byte)},
					rsv: 1'b0, last: 1'b0};
				nn = nn + 2'd1;
				ncnt = 2'd0;
			end else begin
				if (dcnt_q != 2'd0) begin
					nl[nn] = '{data: dh0_q, rsv: 1'b0, last: 1'b0};
					nn = nn + 2'd1;
				end
				if (dcnt_q == 2'd2) begin
					nl[nn] = '{data: dh1_q, rsv: 1'b0, last: 1'b0};
					nn = nn + 2'd1;
				end
				if (in_byte == upn_pkg::PCT) begin
					nh0  = upn_pkg::PCT;
					ncnt = 2'd1;
				end else begin
					nl[nn] = '{data: in_byte, rsv: 1'b0, last: 1'b0};
					nn = nn + 2'd1;
					ncnt = 2'd0;
				end
			end
			if (in_last) begin
				if (ncnt != 2'd0) begin
					nl[nn] = '{data: nh0, rsv: 1'b0, last: 1'b0};
					nn = nn + 2'd1;
				end
				if (ncnt == 2'd2) begin
					nl[nn] = '{data: nh1, rsv: 1'b0, last: 1'b0};
					nn = nn + 2'd1;
				end
				ncnt = 2'd0;
				// a final byte always leaves at least one token
				nl[nn - 2'd1].last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= 2'd0;
			rem_q  <= 2'd0;
			idx_q  <= 2'd0;
		end else if (accept) begin
			dcnt_q <= ncnt;
			rem_q  <= nn;
			idx_q  <= 2'd0;
		end else if (emit) begin
			rem_q <= rem_q - 2'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dh0_q  <= nh0;
			dh1_q  <= nh1;
			list_q <= nl;
		end
	end

endmodule

>>> design/upn_back.sv
// Escape back end: takes decoded tokens, emits normalized bytes one per cycle unless out_full is high.
module upn_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             tok_empty,
	input  upn_pkg::tok_t    tok_data,
	output logic             tok_pop,
	output logic             out_push,
	output logic [7:0]       out_data,
	output logic             out_last,
	input  logic             out_full
);

	logic [1:0] ecnt_q;
	logic [7:0] eh0_q, eh1_q;
	upn_pkg::unit_t units_q [3];
	logic [1:0] rem_q, idx_q, sub_q;
	logic last_q;

	upn_pkg::unit_t nu [3];
	logic [1:0] nn, ncnt;
	logic [7:0] nh0, nh1, d;
	upn_pkg::unit_t cur;
	logic busy, emit, unit_done, final_byte, take;

	assign busy       = (rem_q != 2'd0);
	assign emit       = busy && !out_full;
	assign cur        = units_q[idx_q];
	assign unit_done  = !cur.esc || (sub_q == 2'd2);
	assign final_byte = unit_done && (rem_q == 2'd1);
	assign take       = !tok_empty && (!busy || (emit && final_byte));
	assign tok_pop    = take;
	assign out_push   = emit;
	assign out_last   = final_byte && last_q;

	always_comb begin
		if (!cur.esc) begin
			out_data = cur.data;
		end else begin
			case (sub_q)
				2'd0: out_data = upn_pkg::PCT;
				2'd1: out_data = upn_pkg::hex_char(4'((cur.data & upn_pkg::HI_MASK) >> 4));
				default: out_data = upn_pkg::hex_char(4'(cur.data & upn_pkg::LO_MASK));
			endcase
		end
	end

	// Expand one token into at most three units; held '%' sequences wait for hex digits.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nu[i] = '0;
		end
		nn   = 2'd0;
		ncnt = ecnt_q;
		nh0  = eh0_q;
		nh1  = eh1_q;
		d    = tok_data.data;
		if (tok_data.rsv) begin
			if (ecnt_q != 2'd0) begin
				nu[nn] = '{data: eh0_q, esc: upn_pkg::needs_esc(eh0_q)};
				nn = nn + 2'd1;
			end
			if (ecnt_q == 2'd2) begin
				nu[nn] = '{data: eh1_q, esc: upn_pkg::needs_esc(eh1_q)};
				nn = nn + 2'd1;
			end
			nu[nn] = '{data: d, esc: 1'b0};
			nn = nn + 2'd1;
			ncnt = 2'd0;
		end else begin
			if (ecnt_q == 2'd1 && upn_pkg::is_hex(d)) begin
				nh1  = d;
				ncnt = 2'd2;
			end else if (ecnt_q == 2'd2 && upn_pkg::is_hex(d)) begin
				// valid escape kept verbatim
				nu[0] = '{data: eh0_q, esc: 1'b0};
				nu[1] = '{data: eh1_q, esc: 1'b0};
				nu[2] = '{data: d, esc: 1'b0};
				nn = 2'd3;
				ncnt = 2'd0;
			end else begin
				if (ecnt_q != 2'd0) begin
					nu[nn] = '{data: eh0_q, esc: upn_pkg::needs_esc(eh0_q)};
					nn = nn + 2'd1;
				end
				if (ecnt_q == 2'd2) begin
					nu[nn] = '{data: eh1_q, esc: upn_pkg::needs_esc(eh1_q)};
					nn = nn + 2'd1;
				end
				if (d == upn_pkg::PCT) begin
					nh0  = upn_pkg::PCT;
					ncnt = 2'd1;
				end else begin
					nu[nn] = '{data: d, esc: upn_pkg::needs_esc(d)};
					nn = nn + 2'd1;
					ncnt = 2'd0;
				end
			end
			if (tok_data.last) begin
				if (ncnt != 2'd0) begin
					nu[nn] = '{data: nh0, esc: upn_pkg::needs_esc(nh0)};
					nn = nn + 2'd1;
				end
				if (ncnt == 2'd2) begin
					nu[nn] = '{data: nh1, esc: upn_pkg::needs_esc(nh1)};
					nn = nn + 2'd1;
				end
				ncnt = 2'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ecnt_q <= 2'd0;
			rem_q  <= 2'd0;
			idx_q  <= 2'd0;
			sub_q  <= 2'd0;
		end else if (take) begin
			ecnt_q <= ncnt;
			rem_q  <= nn;
			idx_q  <= 2'd0;
			sub_q  <= 2'd0;
		end else if (emit) begin
			if (unit_done) begin
				rem_q <= rem_q - 2'd1;
				idx_q <= idx_q + 2'd1;
				sub_q <= 2'd0;
			end else begin
				sub_q <= sub_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			eh0_q   <= nh0;
			eh1_q   <= nh1;
			units_q <= nu;
			last_q  <= tok_data.last;
		end
	end

endmodule

>>> design/url_percent_normalizer.sv
// URL normalizer top level: decode front, token queue, escape back end, output queue.
//
// Input channel: push/full. A raw URL byte (in_byte) is taken at a clock edge with push
// high and full low; in_last marks the final byte of a string.
// Output channel: empty/pop. The oldest normalized byte (out_byte, out_last) is shown
// while empty is low and leaves at an edge with pop high. out_last flags the final
// output byte produced by a string's last input byte.
// Path: a byte that passes straight through is registered in the front list, the token
// queue, the back-end unit list and the output queue before it reaches the output ports.
// Throughput: the back end writes one output byte per cycle unless the output queue is
// full; an item yields 1 output byte for a plain byte, 3 for a byte that becomes %XX,
// up to 7 for a token that flushes held escapes. The front issues one decoded token per
// cycle unless the token queue is full; the queue (TOK_DEPTH) lets it outrun the back end.
// Reset (arst_n low) empties both queues and drops all held escape bytes; full is low
// and empty high. When the receiver stops popping, the output queue fills, the back
// end stalls, then the token queue, and finally full rises; nothing is lost.
module url_percent_normalizer #(
	parameter int TOK_DEPTH = 4,
	parameter int OUT_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       full,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       empty
);

	logic tok_push, tok_full, tok_pop, tok_empty;
	upn_pkg::tok_t tok_wdata, tok_rdata;
	logic [upn_pkg::TOK_W-1:0] tok_rbits;
	logic opush, ofull, olast;
	logic [7:0] obyte;
	logic [8:0] orbits;

	upn_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.in_byte  (in_byte),
		.in_last  (in_last),
		.full     (full),
		.tok_push (tok_push),
		.tok_data (tok_wdata),
		.tok_full (tok_full)
	);

	upn_fifo #(
		.W     (upn_pkg::TOK_W),
		.DEPTH (TOK_DEPTH)
	) u_tok_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (tok_push),
		.wdata  (tok_wdata),
		.full   (tok_full),
		.pop    (tok_pop),
		.rdata  (tok_rbits),
		.empty  (tok_empty)
	);

	assign tok_rdata = upn_pkg::tok_t'(tok_rbits);

	upn_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_empty (tok_empty),
		.tok_data  (tok_rdata),
		.tok_pop   (tok_pop),
		.out_push  (opush),
		.out_data  (obyte),
		.out_last  (olast),
		.out_full  (ofull)
	);

	upn_fifo #(
		.W     (9),
		.DEPTH (OUT_DEPTH)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (opush),
		.wdata  ({obyte, olast}),
		.full   (ofull),
		.pop    (pop),
		.rdata  (orbits),
		.empty  (empty)
	);

	assign out_byte = orbits[8:1];
	assign out_last = orbits[0];

endmodule

>>> design/upn_checker.sv
// Port-level checks for the URL normalizer, bound to the top level.
module upn_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic [7:0] in_byte,
	input logic       in_last,
	input logic       full,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       out_last,
	input logic       empty
);

	// reset leaves nothing to deliver
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("output not empty during reset");

	a_reset_not_full: assert property (@(posedge clk) !arst_n |-> !full)
		else $error("input full during reset");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
		else $error("waiting output item changed");

	// unsafe characters must always leave escaped
	a_no_unsafe: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(out_byte == 8'h20 || out_byte == 8'h22 || out_byte == 8'h3c ||
			out_byte == 8'h3e || out_byte == 8'h00 || out_byte == 8'h23 ||
			out_byte == 8'h5c))
		else $error("unescaped unsafe byte on output");

endmodule

bind url_percent_normalizer upn_checker u_upn_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.push     (push),
	.in_byte  (in_byte),
	.in_last  (in_last),
	.full     (full),
	.pop      (pop),
	.out_byte (out_byte),
	.out_last (out_last),
	.empty    (empty)
);
